FILE: sv/mipl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipl_pkg: shared types and constants for the MAC-to-IP learning table
// Operation and status codes, table entry layout, result word layout and
// the configuration register map.
// ----------------------------------------------------------------------------
package mipl_pkg;

	localparam int MAC_W  = 48;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 6;
	localparam int CFG_W  = 7;

	// Configuration register map
	localparam int          APB_AW         = 3;
	localparam int          APB_DW         = 32;
	localparam logic        REG_ENTRIES    = 1'b0;  // paddr[2]
	localparam logic [6:0]  ENTRIES_RESET  = 7'd64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_NOT_FOUND    = 2'd1,
		STS_OUT_OF_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              was_hit;
		logic              evicted;
		logic [IP_W-1:0]   found_ip;
		logic [PORT_W-1:0] found_port;
	} result_t;

endpackage

FILE: sv/mipl_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipl_table_mem: table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mipl_table_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  mipl_pkg::entry_t    wr_data,
	input  logic [AW-1:0]       rd_addr,
	output mipl_pkg::entry_t    rd_data
);

	mipl_pkg::entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: sv/mipl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipl_cfg_regs: configuration register block
// APB-style port holding the entries_in_use register.
// ----------------------------------------------------------------------------
module mipl_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mipl_pkg::APB_AW-1:0]       paddr,
	input  logic [mipl_pkg::APB_DW-1:0]       pwdata,
	output logic [mipl_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	output logic [mipl_pkg::CFG_W-1:0]        entries_in_use
);

	logic                        wr_hit;
	logic [mipl_pkg::CFG_W-1:0]  entries_q;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == mipl_pkg::REG_ENTRIES);

	// entries_in_use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= mipl_pkg::ENTRIES_RESET;
		end else if (wr_hit) begin
			entries_q <= pwdata[mipl_pkg::CFG_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == mipl_pkg::REG_ENTRIES) begin
			prdata = mipl_pkg::APB_DW'(entries_q);
		end
	end

	assign entries_in_use = entries_q;

endmodule

FILE: sv/mipl_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipl_engine: search and update sequencer
// Clears the table after reset, then for each insert or lookup word scans the
// active slots through the memory read port, tracking first match, first free
// slot and oldest stamp; an insert, or a remove of an in-range slot, commits with one write.
// ----------------------------------------------------------------------------
module mipl_engine #(
	parameter int CAPACITY = 64,
	parameter int IW       = 6,
	parameter int CW       = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mipl_pkg::CFG_W-1:0]         cfg_entries,
	// request
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mipl_pkg::op_t                      in_op,
	input  logic [mipl_pkg::MAC_W-1:0]         in_mac,
	input  logic [mipl_pkg::IP_W-1:0]          in_ip,
	input  logic [mipl_pkg::PORT_W-1:0]        in_port,
	input  logic [mipl_pkg::TIME_W-1:0]        in_now,
	input  logic [mipl_pkg::SLOT_W-1:0]        in_rem,
	// result
	output logic                               res_valid,
	input  logic                               res_ready,
	output mipl_pkg::result_t                  res,
	// memory
	output logic                               wr_en,
	output logic [IW-1:0]                      wr_addr,
	output mipl_pkg::entry_t                   wr_data,
	output logic [IW-1:0]                      rd_addr,
	input  mipl_pkg::entry_t                   rd_data
);

	localparam int WW = (CW > mipl_pkg::CFG_W) ? CW : mipl_pkg::CFG_W;

	mipl_pkg::state_t state_q, state_d;

	// latched request
	mipl_pkg::op_t                   op_q;
	logic [mipl_pkg::MAC_W-1:0]      mac_q;
	logic [mipl_pkg::IP_W-1:0]       ip_q;
	logic [mipl_pkg::PORT_W-1:0]     port_q;
	logic [mipl_pkg::TIME_W-1:0]     now_q;
	logic [mipl_pkg::SLOT_W-1:0]     rem_q;
	logic [CW-1:0]                   n_q;

	// scan counters and read pipeline
	logic [IW-1:0]  clr_idx_q;
	logic [CW-1:0]  rd_idx_q;
	logic           rvalid_s1;
	logic [IW-1:0]  ridx_s1;

	// scan findings
	logic                          hit_q, free_q, old_q;
	logic [IW-1:0]                 hit_idx_q, free_idx_q, old_idx_q;
	logic [mipl_pkg::IP_W-1:0]     hit_ip_q;
	logic [mipl_pkg::PORT_W-1:0]   hit_port_q;
	logic [mipl_pkg::TIME_W-1:0]   old_stamp_q;

	logic          accept, issue, scan_done, clr_last, commit;
	logic [WW-1:0] cfg_w, n_w;
	logic [IW-1:0] ins_idx, rem_idx;
	logic [WW-1:0] ins_w, rem_w, hit_w;
	logic          rem_ok;

	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == mipl_pkg::ST_SCAN) && (rd_idx_q < n_q);
	assign scan_done = (rd_idx_q == n_q) && !rvalid_s1;
	assign clr_last  = (clr_idx_q == IW'(CAPACITY - 1));
	assign commit    = (state_q == mipl_pkg::ST_FINISH) && res_ready;

	// active slot count: zero acts as one, clamp at capacity
	always_comb begin
		cfg_w = WW'(cfg_entries);
		n_w   = cfg_w;
		if (cfg_w == '0) begin
			n_w = WW'(1);
		end else if (cfg_w > WW'(CAPACITY)) begin
			n_w = WW'(CAPACITY);
		end
	end

	// slot chosen by insert: match, else first free, else oldest
	always_comb begin
		if (hit_q) begin
			ins_idx = hit_idx_q;
		end else if (free_q) begin
			ins_idx = free_idx_q;
		end else begin
			ins_idx = old_idx_q;
		end
		ins_w   = WW'(ins_idx);
		hit_w   = WW'(hit_idx_q);
		rem_w   = WW'(rem_q);
		rem_idx = rem_w[IW-1:0];
		rem_ok  = rem_w < WW'(n_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mipl_pkg::ST_CLEAR: begin
				if (clr_last) state_d = mipl_pkg::ST_IDLE;
			end
			mipl_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_op == mipl_pkg::OP_INSERT || in_op == mipl_pkg::OP_LOOKUP) begin
						state_d = mipl_pkg::ST_SCAN;
					end else begin
						state_d = mipl_pkg::ST_FINISH;
					end
				end
			end
			mipl_pkg::ST_SCAN: begin
				if (scan_done) state_d = mipl_pkg::ST_FINISH;
			end
			mipl_pkg::ST_FINISH: begin
				if (res_ready) state_d = mipl_pkg::ST_IDLE;
			end
			default: state_d = mipl_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, result word, memory write
	always_comb begin
		in_ready  = (state_q == mipl_pkg::ST_IDLE);
		res_valid = (state_q == mipl_pkg::ST_FINISH);
		rd_addr   = rd_idx_q[IW-1:0];
		res       = '0;
		res.status = mipl_pkg::STS_OK;
		wr_en     = 1'b0;
		wr_addr   = clr_idx_q;
		wr_data   = '0;

		unique case (op_q)
			mipl_pkg::OP_INSERT: begin
				res.slot    = ins_w[mipl_pkg::SLOT_W-1:0];
				res.was_hit = hit_q;
				res.evicted = !hit_q && !free_q;
			end
			mipl_pkg::OP_LOOKUP: begin
				if (hit_q) begin
					res.slot       = hit_w[mipl_pkg::SLOT_W-1:0];
					res.was_hit    = 1'b1;
					res.found_ip   = hit_ip_q;
					res.found_port = hit_port_q;
				end else begin
					res.status = mipl_pkg::STS_NOT_FOUND;
				end
			end
			mipl_pkg::OP_REMOVE: begin
				res.slot = rem_q;
				if (!rem_ok) res.status = mipl_pkg::STS_OUT_OF_RANGE;
			end
			default: begin
			end
		endcase

		if (state_q == mipl_pkg::ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (commit && op_q == mipl_pkg::OP_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = ins_idx;
			wr_data = '{valid: 1'b1, mac: mac_q, ip: ip_q, port: port_q, stamp: now_q};
		end else if (commit && op_q == mipl_pkg::OP_REMOVE && rem_ok) begin
			wr_en   = 1'b1;
			wr_addr = rem_idx;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mipl_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			rd_idx_q  <= '0;
			rvalid_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			old_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= issue;
			if (state_q == mipl_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end
			if (accept) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				old_q    <= 1'b0;
			end else begin
				if (issue) rd_idx_q <= rd_idx_q + CW'(1);
				if (rvalid_s1) begin
					if (rd_data.valid && rd_data.mac == mac_q) hit_q <= 1'b1;
					if (!rd_data.valid) free_q <= 1'b1;
					if (rd_data.valid) old_q <= 1'b1;
				end
			end
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		ridx_s1 <= rd_idx_q[IW-1:0];
		if (accept) begin
			op_q   <= in_op;
			mac_q  <= in_mac;
			ip_q   <= in_ip;
			port_q <= in_port;
			now_q  <= in_now;
			rem_q  <= in_rem;
			n_q    <= CW'(n_w);
		end else if (rvalid_s1) begin
			// first match
			if (rd_data.valid && rd_data.mac == mac_q && !hit_q) begin
				hit_idx_q  <= ridx_s1;
				hit_ip_q   <= rd_data.ip;
				hit_port_q <= rd_data.port;
			end
			// first free slot
			if (!rd_data.valid && !free_q) begin
				free_idx_q <= ridx_s1;
			end
			// oldest stamp, lowest index on a tie
			if (rd_data.valid && (!old_q || rd_data.stamp < old_stamp_q)) begin
				old_idx_q   <= ridx_s1;
				old_stamp_q <= rd_data.stamp;
			end
		end
	end

endmodule

FILE: sv/mac_to_ip_learning_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_to_ip_learning_table_core: MAC-to-IPv4 learning table
// Fully associative table with insert/refresh, lookup and remove.
//
//  channel  | direction | signals
//  ---------+-----------+----------------------------------------------
//  s_*      | in        | request word: tuser op, tdata key and binding
//  m_*      | out       | result word: tuser status, tdata slot and data
//  apb      | in        | entries_in_use register at byte address 0
//
// Insert and lookup scan the n active slots, n the active slot count: the
// single memory read port visits one slot per cycle. Remove and the unused
// code skip the scan. A new word is taken only once the last one is committed.
// After reset a clearing pass writes every slot before the first word is taken. A
// result waits in the output register while the next request is already accepted;
// a stalled result holds the engine only at its final commit.
// ----------------------------------------------------------------------------
module mac_to_ip_learning_table_core #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// request stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [135:0]  s_tdata,   // mac_key, ip_address, udp_port, now_seconds,
	                                 // slot_to_remove, zero fill
	input  logic [1:0]    s_tuser,   // operation
	// result stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [55:0]   m_tdata,   // slot, was_hit, evicted, found_ip, found_port
	output logic [1:0]    m_tuser,   // status
	// configuration
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [mipl_pkg::CFG_W-1:0] cfg_entries;
	logic                       res_valid, res_ready;
	mipl_pkg::result_t          res, out_q;
	logic                       m_tvalid_q;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr, rd_addr;
	mipl_pkg::entry_t           wr_data, rd_data;

	mipl_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.entries_in_use (cfg_entries)
	);

	mipl_engine #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.CW       (CW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_entries (cfg_entries),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (mipl_pkg::op_t'(s_tuser)),
		.in_mac      (s_tdata[47:0]),
		.in_ip       (s_tdata[79:48]),
		.in_port     (s_tdata[95:80]),
		.in_now      (s_tdata[127:96]),
		.in_rem      (s_tdata[133:128]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	mipl_table_mem #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.found_port, out_q.found_ip, out_q.evicted,
	                   out_q.was_hit, out_q.slot};

`ifndef SYNTHESIS
	// one word in flight: no second request right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while previous still in work");

	// a valid entry is written only as an insert commits its result
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data.valid) |-> (res_valid && res_ready))
		else $error("table entry written without a committed result");

	// a lookup miss reports no hit and no data
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == mipl_pkg::STS_NOT_FOUND) |->
		(!res.was_hit && res.found_ip == '0 && res.found_port == '0))
		else $error("lookup miss carries hit data");
`endif

endmodule
